>>> sv/emoji_cluster_style_resolver_unit_macros.svh
// Assertion macros for the emoji cluster style resolver.
`ifndef EMOJI_CLUSTER_STYLE_RESOLVER_UNIT_MACROS_SVH
`define EMOJI_CLUSTER_STYLE_RESOLVER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off while reset is low.
`define ECSR_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off while reset is low.
`define ECSR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/ecsr_pkg.sv
// Types, codes and code point constants of the emoji cluster style resolver.
`default_nettype none

package ecsr_pkg;

    localparam int CP_W = 21;

    // Input opcodes
    localparam logic [1:0] OP_CLUSTER = 2'd0;
    localparam logic [1:0] OP_PROP    = 2'd1;
    localparam logic [1:0] OP_PRES    = 2'd2;

    // Result styles
    localparam logic [1:0] STYLE_NONE  = 2'd0;
    localparam logic [1:0] STYLE_TEXT  = 2'd1;
    localparam logic [1:0] STYLE_EMOJI = 2'd2;

    // Held variation selector
    localparam logic [1:0] SEL_NONE  = 2'd0;
    localparam logic [1:0] SEL_TEXT  = 2'd1;
    localparam logic [1:0] SEL_EMOJI = 2'd2;

    // Presentation policy
    localparam logic [1:0] POL_DEFAULT = 2'd0;
    localparam logic [1:0] POL_TEXT    = 2'd1;
    localparam logic [1:0] POL_EMOJI   = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] REG_PROP_COUNT = 2'd0;
    localparam logic [1:0] REG_PRES_COUNT = 2'd1;
    localparam logic [1:0] REG_POLICY     = 2'd2;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    // Special code points
    localparam logic [CP_W-1:0] CP_VS_TEXT    = 21'h00fe0e;
    localparam logic [CP_W-1:0] CP_VS_EMOJI   = 21'h00fe0f;
    localparam logic [CP_W-1:0] CP_ZWJ        = 21'h00200d;
    localparam logic [CP_W-1:0] CP_KEYCAP     = 21'h0020e3;
    localparam logic [CP_W-1:0] CP_RI_LOW     = 21'h01f1e6;
    localparam logic [CP_W-1:0] CP_RI_HIGH    = 21'h01f1ff;
    localparam logic [CP_W-1:0] CP_MOD_LOW    = 21'h01f3fb;
    localparam logic [CP_W-1:0] CP_MOD_HIGH   = 21'h01f3ff;
    localparam logic [CP_W-1:0] CP_TAG_LOW    = 21'h0e0020;
    localparam logic [CP_W-1:0] CP_TAG_HIGH   = 21'h0e007e;
    localparam logic [CP_W-1:0] CP_TAG_END    = 21'h0e007f;
    localparam logic [CP_W-1:0] CP_BLACK_FLAG = 21'h01f3f4;
    localparam logic [CP_W-1:0] CP_HASH       = 21'h000023;
    localparam logic [CP_W-1:0] CP_STAR       = 21'h00002a;
    localparam logic [CP_W-1:0] CP_DIGIT_0    = 21'h000030;
    localparam logic [CP_W-1:0] CP_DIGIT_9    = 21'h000039;

    typedef struct packed {
        logic [1:0]      opcode;
        logic [CP_W-1:0] code_point;
        logic [CP_W-1:0] range_first;
        logic [CP_W-1:0] range_last;
        logic [8:0]      entry_index;
        logic            last_of_cluster;
    } t_in_item;

    typedef struct packed {
        logic [CP_W-1:0] base_code_point;
        logic [1:0]      style;
        logic            needs_composition;
    } t_out_item;

    typedef struct packed {
        logic [CP_W-1:0] first;
        logic [CP_W-1:0] last;
    } t_range;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PROBE,
        ST_CMP,
        ST_FIN
    } t_state;

    typedef enum logic {
        TAB_PROP,
        TAB_PRES
    } t_table;

    // Digits, '#' and '*' may start a keycap sequence.
    function automatic logic keycap_base(input logic [CP_W-1:0] cp);
        return (cp == CP_HASH) || (cp == CP_STAR) ||
               ((cp >= CP_DIGIT_0) && (cp <= CP_DIGIT_9));
    endfunction

endpackage

`default_nettype wire

>>> sv/emoji_cluster_style_resolver_unit.sv
// Emoji cluster style resolver: cluster mark tracking and range table search.
//
// Input channel (i_in_valid / o_in_stall / i_in_item): one transaction per
// code point of a grapheme cluster (last_of_cluster on the final one), or a
// range load into the emoji property or default presentation table.
// Output channel (o_out_valid / i_out_stall / o_out_item): one transaction
// per finished cluster with base code point, style and composition flag.
// Config port (i_cfg_wr_en / i_cfg_index / i_cfg_wdata): range counts and
// presentation policy, to be written by the user only while the block is idle; the block itself does not check this.
// Range loads and non-final code points are taken while the block is idle. A
// final code point starts the property search, then the presentation search if
// needed, then a final step; the input stalls until the final step is done. Each
// search makes at most ceil(log2(count+1)) probes. The presentation table is
// searched only on a property hit when the policy and marks leave the default
// style open. Each probe is a registered memory read plus one pass through the
// shared compare.
// Reset clears config and cluster state; tables are not cleared and must be
// loaded before they are searched.
// A stalled result sits in the output register while new code points are
// taken; the next cluster end waits in its final step until it frees up.
`default_nettype none

`include "emoji_cluster_style_resolver_unit_macros.svh"

module emoji_cluster_style_resolver_unit #(
    parameter int PROPERTY_RANGES     = 512,
    parameter int PRESENTATION_RANGES = 256
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_in_valid,
    output logic                                o_in_stall,
    input  ecsr_pkg::t_in_item                  i_in_item,
    output logic                                o_out_valid,
    input  wire                                 i_out_stall,
    output ecsr_pkg::t_out_item                 o_out_item,
    input  wire                                 i_cfg_wr_en,
    input  wire  [ecsr_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire  [ecsr_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);

    localparam int PIW   = $clog2(PROPERTY_RANGES);
    localparam int QIW   = $clog2(PRESENTATION_RANGES);
    localparam int PBW   = $clog2(PROPERTY_RANGES + 1);
    localparam int QBW   = $clog2(PRESENTATION_RANGES + 1);
    localparam int SW    = (PBW > QBW) ? PBW : QBW;
    localparam int CW    = (SW > ecsr_pkg::CFG_DATA_W) ? SW : ecsr_pkg::CFG_DATA_W;
    localparam int CP_W  = ecsr_pkg::CP_W;

    // Config registers
    logic [9:0] r_prop_count;
    logic [8:0] r_pres_count;
    logic [1:0] r_policy;

    // Cluster state
    logic [CP_W-1:0] r_base,        n_base;
    logic            r_first_pending, n_first_pending;
    logic [1:0]      r_sel,         n_sel;
    logic            r_joiner,      n_joiner;
    logic            r_keycap,      n_keycap;
    logic [1:0]      r_ri_count,    n_ri_count;
    logic            r_tag,         n_tag;
    logic            r_tag_end,     n_tag_end;
    logic            r_comp,        n_comp;

    // Sequencer and search state
    ecsr_pkg::t_state r_state, n_state;
    ecsr_pkg::t_table r_tab,   n_tab;
    logic [SW-1:0]    r_lo,    n_lo;
    logic [SW-1:0]    r_hi,    n_hi;
    logic [SW-1:0]    r_mid,   n_mid;
    logic [1:0]       r_style, n_style;

    // Output register
    logic                r_out_valid, n_out_valid;
    ecsr_pkg::t_out_item r_out_item,  n_out_item;

    // Tables
    ecsr_pkg::t_range prop_mem [PROPERTY_RANGES];
    ecsr_pkg::t_range pres_mem [PRESENTATION_RANGES];
    ecsr_pkg::t_range r_prop_rd;
    ecsr_pkg::t_range r_pres_rd;

    logic                in_accept;
    logic                prop_wr;
    logic                pres_wr;
    logic [SW:0]         w_sum;
    logic [SW-1:0]       w_mid;
    logic [CW-1:0]       prop_lim_w;
    logic [CW-1:0]       pres_lim_w;
    logic [SW-1:0]       prop_lim;
    logic [SW-1:0]       pres_lim;
    ecsr_pkg::t_range    probe;
    logic                cp_below;
    logic                cp_above;
    logic                search_done;
    logic                search_hit;
    logic                out_free;
    logic                base_kc;
    logic [CP_W-1:0]     cp;

    assign in_accept = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != ecsr_pkg::ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item = r_out_item;
    assign out_free = !r_out_valid || !i_out_stall;
    assign cp = i_in_item.code_point;

    assign prop_wr = in_accept && (i_in_item.opcode == ecsr_pkg::OP_PROP) &&
                     (32'(i_in_item.entry_index) < PROPERTY_RANGES);
    assign pres_wr = in_accept && (i_in_item.opcode == ecsr_pkg::OP_PRES) &&
                     (32'(i_in_item.entry_index) < PRESENTATION_RANGES);

    // Counts above the table size search the whole table
    assign prop_lim_w = (CW'(r_prop_count) > CW'(PROPERTY_RANGES)) ?
                        CW'(PROPERTY_RANGES) : CW'(r_prop_count);
    assign pres_lim_w = (CW'(r_pres_count) > CW'(PRESENTATION_RANGES)) ?
                        CW'(PRESENTATION_RANGES) : CW'(r_pres_count);
    assign prop_lim = prop_lim_w[SW-1:0];
    assign pres_lim = pres_lim_w[SW-1:0];

    // Shared probe datapath: midpoint and range compare
    assign w_sum = {1'b0, r_lo} + {1'b0, r_hi};
    assign w_mid = w_sum[SW:1];
    assign probe = (r_tab == ecsr_pkg::TAB_PRES) ? r_pres_rd : r_prop_rd;
    assign cp_below = (r_base < probe.first);
    assign cp_above = (r_base > probe.last);
    assign base_kc = ecsr_pkg::keycap_base(r_base);

    assign search_done = ((r_state == ecsr_pkg::ST_PROBE) && !(r_lo < r_hi)) ||
                         ((r_state == ecsr_pkg::ST_CMP) && !cp_below && !cp_above);
    assign search_hit  = (r_state == ecsr_pkg::ST_CMP);

    // Property table
    always_ff @(posedge i_clk) begin
        if (prop_wr) begin
            prop_mem[PIW'(i_in_item.entry_index)] <= {i_in_item.range_first,
                                                      i_in_item.range_last};
        end
        r_prop_rd <= prop_mem[w_mid[PIW-1:0]];
    end

    // Presentation table
    always_ff @(posedge i_clk) begin
        if (pres_wr) begin
            pres_mem[QIW'(i_in_item.entry_index)] <= {i_in_item.range_first,
                                                      i_in_item.range_last};
        end
        r_pres_rd <= pres_mem[w_mid[QIW-1:0]];
    end

    // Config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prop_count <= '0;
            r_pres_count <= '0;
            r_policy     <= ecsr_pkg::POL_DEFAULT;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                ecsr_pkg::REG_PROP_COUNT: r_prop_count <= i_cfg_wdata[9:0];
                ecsr_pkg::REG_PRES_COUNT: r_pres_count <= i_cfg_wdata[8:0];
                ecsr_pkg::REG_POLICY:     r_policy     <= i_cfg_wdata[1:0];
                default: ;
            endcase
        end
    end

    // Next state, cluster marks and search steps
    always_comb begin
        n_state         = r_state;
        n_tab           = r_tab;
        n_lo            = r_lo;
        n_hi            = r_hi;
        n_mid           = r_mid;
        n_style         = r_style;
        n_base          = r_base;
        n_first_pending = r_first_pending;
        n_sel           = r_sel;
        n_joiner        = r_joiner;
        n_keycap        = r_keycap;
        n_ri_count      = r_ri_count;
        n_tag           = r_tag;
        n_tag_end       = r_tag_end;
        n_comp          = r_comp;
        n_out_valid     = r_out_valid && i_out_stall;
        n_out_item      = r_out_item;

        case (r_state)
            ecsr_pkg::ST_IDLE: begin
                if (in_accept && (i_in_item.opcode == ecsr_pkg::OP_CLUSTER)) begin
                    if (r_first_pending) begin
                        n_base          = cp;
                        n_first_pending = 1'b0;
                    end else if ((r_sel == ecsr_pkg::SEL_NONE) &&
                                 (cp inside {ecsr_pkg::CP_VS_TEXT,
                                             ecsr_pkg::CP_VS_EMOJI})) begin
                        n_sel = (cp == ecsr_pkg::CP_VS_TEXT) ?
                                ecsr_pkg::SEL_TEXT : ecsr_pkg::SEL_EMOJI;
                    end
                    if (cp == ecsr_pkg::CP_ZWJ) begin
                        n_joiner = 1'b1;
                    end else if (r_joiner &&
                                 !(cp inside {ecsr_pkg::CP_VS_TEXT,
                                              ecsr_pkg::CP_VS_EMOJI})) begin
                        n_comp   = 1'b1;
                        n_joiner = 1'b0;
                    end
                    if (cp == ecsr_pkg::CP_KEYCAP) begin
                        n_keycap = 1'b1;
                    end
                    // Skin tone modifier after the base
                    if (!r_first_pending &&
                        (cp inside {[ecsr_pkg::CP_MOD_LOW:ecsr_pkg::CP_MOD_HIGH]})) begin
                        n_comp = 1'b1;
                    end
                    if ((cp inside {[ecsr_pkg::CP_RI_LOW:ecsr_pkg::CP_RI_HIGH]}) &&
                        (r_ri_count < 2'd2)) begin
                        n_ri_count = r_ri_count + 2'd1;
                    end
                    if (cp inside {[ecsr_pkg::CP_TAG_LOW:ecsr_pkg::CP_TAG_HIGH]}) begin
                        n_tag = 1'b1;
                    end
                    if (cp == ecsr_pkg::CP_TAG_END) begin
                        n_tag_end = 1'b1;
                    end
                    if (i_in_item.last_of_cluster) begin
                        n_tab   = ecsr_pkg::TAB_PROP;
                        n_lo    = '0;
                        n_hi    = prop_lim;
                        n_state = ecsr_pkg::ST_PROBE;
                    end
                end
            end

            ecsr_pkg::ST_PROBE: begin
                // Table read at w_mid is issued this cycle
                n_mid = w_mid;
                if (r_lo < r_hi) begin
                    n_state = ecsr_pkg::ST_CMP;
                end
            end

            ecsr_pkg::ST_CMP: begin
                n_state = ecsr_pkg::ST_PROBE;
                if (cp_below) begin
                    n_hi = r_mid;
                end else if (cp_above) begin
                    n_lo = r_mid + SW'(1);
                end
            end

            ecsr_pkg::ST_FIN: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_item.base_code_point = r_base;
                    n_out_item.style = (base_kc && r_keycap &&
                                        (r_sel != ecsr_pkg::SEL_TEXT)) ?
                                       ecsr_pkg::STYLE_EMOJI : r_style;
                    n_out_item.needs_composition = r_comp ||
                        (base_kc && r_keycap) ||
                        (r_ri_count >= 2'd2) ||
                        ((r_base == ecsr_pkg::CP_BLACK_FLAG) && r_tag && r_tag_end);
                    n_base          = '0;
                    n_first_pending = 1'b1;
                    n_sel           = ecsr_pkg::SEL_NONE;
                    n_joiner        = 1'b0;
                    n_keycap        = 1'b0;
                    n_ri_count      = '0;
                    n_tag           = 1'b0;
                    n_tag_end       = 1'b0;
                    n_comp          = 1'b0;
                    n_state         = ecsr_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = ecsr_pkg::ST_IDLE;
            end
        endcase

        // End of a search: pick the style or move on to the second table
        if (search_done) begin
            n_state = ecsr_pkg::ST_FIN;
            if (r_tab == ecsr_pkg::TAB_PRES) begin
                n_style = search_hit ? ecsr_pkg::STYLE_EMOJI : ecsr_pkg::STYLE_TEXT;
            end else if (!search_hit) begin
                n_style = ecsr_pkg::STYLE_NONE;
            end else if (r_sel == ecsr_pkg::SEL_TEXT) begin
                n_style = ecsr_pkg::STYLE_TEXT;
            end else if (r_sel == ecsr_pkg::SEL_EMOJI) begin
                n_style = ecsr_pkg::STYLE_EMOJI;
            end else if (base_kc) begin
                n_style = ecsr_pkg::STYLE_TEXT;
            end else if (r_policy == ecsr_pkg::POL_DEFAULT) begin
                n_tab   = ecsr_pkg::TAB_PRES;
                n_lo    = '0;
                n_hi    = pres_lim;
                n_state = ecsr_pkg::ST_PROBE;
            end else if (r_policy == ecsr_pkg::POL_EMOJI) begin
                n_style = ecsr_pkg::STYLE_EMOJI;
            end else begin
                n_style = ecsr_pkg::STYLE_TEXT;
            end
        end
    end

    // Control and cluster state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ecsr_pkg::ST_IDLE;
            r_tab           <= ecsr_pkg::TAB_PROP;
            r_out_valid     <= 1'b0;
            r_base          <= '0;
            r_first_pending <= 1'b1;
            r_sel           <= ecsr_pkg::SEL_NONE;
            r_joiner        <= 1'b0;
            r_keycap        <= 1'b0;
            r_ri_count      <= '0;
            r_tag           <= 1'b0;
            r_tag_end       <= 1'b0;
            r_comp          <= 1'b0;
            r_lo            <= '0;
            r_hi            <= '0;
        end else begin
            r_state         <= n_state;
            r_tab           <= n_tab;
            r_out_valid     <= n_out_valid;
            r_base          <= n_base;
            r_first_pending <= n_first_pending;
            r_sel           <= n_sel;
            r_joiner        <= n_joiner;
            r_keycap        <= n_keycap;
            r_ri_count      <= n_ri_count;
            r_tag           <= n_tag;
            r_tag_end       <= n_tag_end;
            r_comp          <= n_comp;
            r_lo            <= n_lo;
            r_hi            <= n_hi;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_mid      <= n_mid;
        r_style    <= n_style;
        r_out_item <= n_out_item;
    end

    `ECSR_ASSERT_NEXT(a_last_starts_search, in_accept && (i_in_item.opcode == ecsr_pkg::OP_CLUSTER) && i_in_item.last_of_cluster, (r_state == ecsr_pkg::ST_PROBE) && (r_tab == ecsr_pkg::TAB_PROP), "cluster end did not start the property search")
    `ECSR_ASSERT_SAME(a_mid_in_window, r_state == ecsr_pkg::ST_CMP, (r_mid >= r_lo) && (r_mid < r_hi), "probe index outside the search window")
    `ECSR_ASSERT_SAME(a_pres_only_default, (r_state != ecsr_pkg::ST_IDLE) && (r_tab == ecsr_pkg::TAB_PRES), (r_policy == ecsr_pkg::POL_DEFAULT) && (r_sel == ecsr_pkg::SEL_NONE), "presentation search outside default policy")
    `ECSR_ASSERT_NEXT(a_fin_emits, (r_state == ecsr_pkg::ST_FIN) && out_free, o_out_valid && r_first_pending && (r_state == ecsr_pkg::ST_IDLE), "cluster end did not emit and clear")

endmodule

`default_nettype wire
